// ===== rtl/spd_pkg.sv =====
// ----------------------------------------------------------------------------
// spd_pkg: shared types and constants of the serial packet deframer
// Frame layout constants, status codes, phase codes and the packet
// descriptor that passes from the parser to the result sequencer.
// ----------------------------------------------------------------------------
package spd_pkg;

    // Frame layout. Positions count from the first header byte.
    localparam int HEADER_LEN   = 2;   // 1..2
    localparam int SPEC_END     = 5;   // 3..8
    localparam int LENGTH_POS   = 2;   // 1..7
    localparam int INDEX_POS    = 3;   // 1..7
    localparam int CHECKSUM_POS = 4;   // 1..7

    localparam int MAX_PAYLOAD_DEF = 32;  // 1..64

    // Spec area positions stay below 8.
    localparam int SPOS_W = 3;

    // Descriptor queue
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = 1;
    localparam int FIFO_CNT_W = 2;

    // Configuration registers
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] REG_SYNC_PATTERN   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_CHECK_SEQUENCE = 1'b1;
    localparam logic [15:0] SYNC_PATTERN_RST   = 16'hAA55;
    localparam logic        CHECK_SEQUENCE_RST = 1'b1;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_BAD_CHECKSUM = 2'd1,
        ST_SEQ_MISMATCH = 2'd2,
        ST_TOO_LONG     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_SPEC    = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_READ = 2'd1,
        BK_HOLD = 2'd2
    } back_state_t;

    // One finished packet: either a payload burst from a buffer bank or a
    // single status result.
    typedef struct packed {
        status_t     status;
        logic [7:0]  seq;
        logic [7:0]  len;
        logic        burst;
        logic        bank;
    } desc_t;

    // Payload buffer address: bank bit on top of the byte offset.
    function automatic int addr_w(input int max_payload);
        return (max_payload > 1) ? $clog2(max_payload) + 1 : 2;
    endfunction

endpackage

// ===== rtl/spd_payload_ram.sv =====
// ----------------------------------------------------------------------------
// spd_payload_ram: two-bank payload buffer
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spd_payload_ram #(
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/spd_desc_fifo.sv =====
// ----------------------------------------------------------------------------
// spd_desc_fifo: packet descriptor queue
// Two-entry queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module spd_desc_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  spd_pkg::desc_t din,
    input  logic          pop,
    output spd_pkg::desc_t dout,
    output logic          empty,
    output logic          full
);
    import spd_pkg::*;

    desc_t                 entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout  = entry_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full || pop)
        else $error("descriptor pushed into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("descriptor popped from an empty queue");

endmodule

// ===== rtl/spd_front.sv =====
// ----------------------------------------------------------------------------
// spd_front: byte parser
// Hunts the sync header, captures the spec bytes, stores and sums the
// payload and turns each finished packet into a descriptor.
// ----------------------------------------------------------------------------
module spd_front #(
    parameter int MAX_PAYLOAD = spd_pkg::MAX_PAYLOAD_DEF,
    parameter int ADDR_W      = spd_pkg::addr_w(MAX_PAYLOAD)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic [15:0]       sync_pattern,
    input  logic              check_sequence,
    input  logic              fifo_full,
    output logic              push,
    output spd_pkg::desc_t    desc,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [7:0]        wr_data
);
    import spd_pkg::*;

    localparam int PAW = ADDR_W - 1;

    phase_t            phase_reg, phase_next;
    logic [SPOS_W-1:0] spos_reg, spos_next;
    logic [7:0]        cnt_reg, cnt_next;
    logic [7:0]        sum_reg, sum_next;
    logic [7:0]        exp_reg, exp_next;
    logic              bank_reg, bank_next;
    logic [7:0]        len_reg, len_next;
    logic [7:0]        idx_reg, idx_next;
    logic [7:0]        chk_reg, chk_next;

    logic       accept, match, store, spec_last, pay_last, finish;
    logic [7:0] hdr_byte, len_cur, idx_cur, chk_cur, sum_add, sum_final;
    status_t    st;

    assign s_tready = !fifo_full;
    assign accept   = s_tvalid && s_tready;
    assign hdr_byte = spos_reg[0] ? sync_pattern[15:8] : sync_pattern[7:0];
    assign match    = (s_tdata == hdr_byte);
    assign store    = accept && ((phase_reg == PH_HUNT && match) || phase_reg == PH_SPEC);
    assign sum_add  = sum_reg + s_tdata;

    // Spec fields, including the byte that arrives this cycle.
    always_comb begin
        len_cur = len_reg;
        idx_cur = idx_reg;
        chk_cur = chk_reg;
        if (store && spos_reg == SPOS_W'(LENGTH_POS))   len_cur = s_tdata;
        if (store && spos_reg == SPOS_W'(INDEX_POS))    idx_cur = s_tdata;
        if (store && spos_reg == SPOS_W'(CHECKSUM_POS)) chk_cur = s_tdata;
        if (LENGTH_POS >= SPEC_END)   len_cur = 8'd0;
        if (INDEX_POS >= SPEC_END)    idx_cur = 8'd0;
        if (CHECKSUM_POS >= SPEC_END) chk_cur = 8'd0;
    end

    assign spec_last = (phase_reg == PH_SPEC) && (spos_reg == SPOS_W'(SPEC_END - 1));
    assign pay_last  = (phase_reg == PH_PAYLOAD) && (cnt_reg + 8'd1 == len_reg);
    assign finish    = accept && ((spec_last && len_cur == 8'd0) || pay_last);
    assign sum_final = (phase_reg == PH_PAYLOAD) ? sum_add : 8'd0;

    // Packet verdict and the expected index that follows from it.
    always_comb begin
        st       = ST_OK;
        exp_next = exp_reg;
        if (finish) begin
            if (sum_final != chk_cur) begin
                st = ST_BAD_CHECKSUM;
            end else begin
                if (check_sequence) begin
                    if (idx_cur == exp_reg) begin
                        exp_next = exp_reg + 8'd1;
                    end else begin
                        exp_next = idx_cur + 8'd1;
                        st       = ST_SEQ_MISMATCH;
                    end
                end
                if (st == ST_OK && len_cur > 8'(MAX_PAYLOAD)) begin
                    st = ST_TOO_LONG;
                end
            end
        end
    end

    assign push       = finish;
    assign desc.status = st;
    assign desc.seq    = idx_cur;
    assign desc.len    = len_cur;
    assign desc.burst  = (st == ST_OK) && (len_cur != 8'd0);
    assign desc.bank   = bank_reg;

    // Store the first MAX_PAYLOAD payload bytes, the rest only count.
    assign wr_en   = accept && (phase_reg == PH_PAYLOAD) && (cnt_reg < 8'(MAX_PAYLOAD));
    assign wr_addr = {bank_reg, cnt_reg[PAW-1:0]};
    assign wr_data = s_tdata;

    always_comb begin
        phase_next = phase_reg;
        spos_next  = spos_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        bank_next  = finish ? !bank_reg : bank_reg;
        len_next   = len_cur;
        idx_next   = idx_cur;
        chk_next   = chk_cur;
        if (accept) begin
            case (phase_reg)
                PH_HUNT: begin
                    if (!match) begin
                        spos_next = '0;
                    end else if (spos_reg == SPOS_W'(HEADER_LEN - 1)) begin
                        phase_next = PH_SPEC;
                        spos_next  = SPOS_W'(HEADER_LEN);
                    end else begin
                        spos_next = spos_reg + 1'b1;
                    end
                end
                PH_SPEC: begin
                    if (!spec_last) begin
                        spos_next = spos_reg + 1'b1;
                    end else if (len_cur == 8'd0) begin
                        phase_next = PH_HUNT;
                        spos_next  = '0;
                    end else begin
                        phase_next = PH_PAYLOAD;
                        cnt_next   = 8'd0;
                        sum_next   = 8'd0;
                    end
                end
                PH_PAYLOAD: begin
                    cnt_next = cnt_reg + 8'd1;
                    sum_next = sum_add;
                    if (pay_last) begin
                        phase_next = PH_HUNT;
                        spos_next  = '0;
                        sum_next   = 8'd0;
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                    spos_next  = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            spos_reg  <= '0;
            cnt_reg   <= 8'd0;
            sum_reg   <= 8'd0;
            exp_reg   <= 8'd0;
            bank_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            spos_reg  <= spos_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            exp_reg   <= exp_next;
            bank_reg  <= bank_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg <= len_next;
        idx_reg <= idx_next;
        chk_reg <= chk_next;
    end

    a_burst_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        push && desc.burst |-> desc.len <= 8'(MAX_PAYLOAD) && desc.len != 8'd0)
        else $error("payload burst does not fit the buffer");

endmodule

// ===== rtl/spd_back.sv =====
// ----------------------------------------------------------------------------
// spd_back: result sequencer
// Turns queued descriptors into result transfers, reading payload bytes
// from the buffer bank that the descriptor names.
// ----------------------------------------------------------------------------
module spd_back #(
    parameter int ADDR_W = spd_pkg::addr_w(spd_pkg::MAX_PAYLOAD_DEF)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  spd_pkg::desc_t    head,
    input  logic              fifo_empty,
    output logic              pop,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [7:0]        rd_data,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,
    output logic [2:0]        m_tuser,
    output logic              m_tlast
);
    import spd_pkg::*;

    localparam int PAW = ADDR_W - 1;

    back_state_t state_reg, state_next;
    logic [7:0]  idx_reg, idx_next;
    status_t     out_status_reg, out_status_next;
    logic [7:0]  out_data_reg, out_data_next;
    logic        out_dv_reg, out_dv_next;
    logic [7:0]  out_seq_reg, out_seq_next;
    logic        out_last_reg, out_last_next;

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_dv_next     = out_dv_reg;
        out_seq_next    = out_seq_reg;
        out_last_next   = out_last_reg;
        pop             = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = {head.bank, idx_reg[PAW-1:0]};
        case (state_reg)
            BK_IDLE: begin
                if (!fifo_empty) begin
                    if (head.burst) begin
                        idx_next   = 8'd0;
                        rd_en      = 1'b1;
                        rd_addr    = {head.bank, {PAW{1'b0}}};
                        state_next = BK_READ;
                    end else begin
                        out_status_next = head.status;
                        out_data_next   = 8'd0;
                        out_dv_next     = 1'b0;
                        out_seq_next    = head.seq;
                        out_last_next   = 1'b1;
                        state_next      = BK_HOLD;
                    end
                end
            end
            BK_READ: begin
                out_status_next = ST_OK;
                out_data_next   = rd_data;
                out_dv_next     = 1'b1;
                out_seq_next    = head.seq;
                out_last_next   = (idx_reg + 8'd1 == head.len);
                state_next      = BK_HOLD;
            end
            BK_HOLD: begin
                if (m_tready) begin
                    if (out_last_reg) begin
                        pop        = 1'b1;
                        state_next = BK_IDLE;
                    end else begin
                        idx_next   = idx_reg + 8'd1;
                        rd_en      = 1'b1;
                        rd_addr    = {head.bank, idx_next[PAW-1:0]};
                        state_next = BK_READ;
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_dv_reg     <= out_dv_next;
        out_seq_reg    <= out_seq_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = (state_reg == BK_HOLD);
    assign m_tdata  = {out_seq_reg, out_data_reg};
    assign m_tuser  = {out_dv_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

    a_pop_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> m_tvalid && m_tready && m_tlast)
        else $error("descriptor released before its last transfer");

    a_data_is_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_dv_reg |-> out_status_reg == ST_OK)
        else $error("payload byte carries a failure status");

endmodule

// ===== rtl/serial_packet_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// serial_packet_deframer_unit: sync-header / length / checksum deframer
// Cuts a received byte stream into packets and delivers good payloads.
// ----------------------------------------------------------------------------
// The input side takes one received byte per cycle. It hunts the sync header
// (a mismatching byte is dropped and the hunt restarts), captures the spec
// bytes (length, sequence index, checksum), then stores and sums the payload.
// Each finished packet becomes a descriptor in a two-entry queue; the output
// side plays it out either as the payload bytes (status ok, data_valid set,
// tlast on the final byte) or as one status transfer (checksum bad, sequence
// mismatch, payload too long, or an empty good packet). The payload buffer
// has two banks, one per queued descriptor, so the parser keeps receiving
// while the previous packet drains; s_tready drops only while both queue
// entries are taken. Each payload byte passes the registered buffer read and
// then the output register; the next read starts only once m_tready takes
// the current byte. Payload beyond MAX_PAYLOAD bytes is counted but not stored.
// The buffer needs no clearing after reset. Write configuration only while idle.
// ----------------------------------------------------------------------------
module serial_packet_deframer_unit #(
    parameter int MAX_PAYLOAD = spd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Received bytes
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] rx_byte
    // Results
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [15:0]                      m_tdata,   // [7:0] data_byte, [15:8] seq_index
    output logic [2:0]                       m_tuser,   // [1:0] status, [2] data_valid
    output logic                             m_tlast,
    // Configuration writes
    input  logic                             cfg_wr_en,
    input  logic [spd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [spd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import spd_pkg::*;

    localparam int ADDR_W = addr_w(MAX_PAYLOAD);

    // Configuration registers
    logic [15:0] sync_pattern_reg, sync_pattern_next;
    logic        check_seq_reg, check_seq_next;

    always_comb begin
        sync_pattern_next = sync_pattern_reg;
        check_seq_next    = check_seq_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SYNC_PATTERN:   sync_pattern_next = cfg_wdata[15:0];
                REG_CHECK_SEQUENCE: check_seq_next    = cfg_wdata[0];
                default: begin
                    sync_pattern_next = sync_pattern_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_pattern_reg <= SYNC_PATTERN_RST;
            check_seq_reg    <= CHECK_SEQUENCE_RST;
        end else begin
            sync_pattern_reg <= sync_pattern_next;
            check_seq_reg    <= check_seq_next;
        end
    end

    // Parser to queue
    logic  push, pop, fifo_full, fifo_empty;
    desc_t desc_in, desc_head;

    // Payload buffer ports
    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [7:0]        wr_data, rd_data;

    // Front: hunt, capture spec, store payload, judge the packet
    spd_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .ADDR_W      (ADDR_W)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .sync_pattern   (sync_pattern_reg),
        .check_sequence (check_seq_reg),
        .fifo_full      (fifo_full),
        .push           (push),
        .desc           (desc_in),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data)
    );

    // Hold finished packets until the output side takes them
    spd_desc_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (desc_in),
        .pop     (pop),
        .dout    (desc_head),
        .empty   (fifo_empty),
        .full    (fifo_full)
    );

    // Two banks of payload bytes
    spd_payload_ram #(
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Back: advance through the head descriptor, one transfer at a time
    spd_back #(
        .ADDR_W (ADDR_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (desc_head),
        .fifo_empty (fifo_empty),
        .pop        (pop),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
